>>> sv/assert_macros.svh
// Assertion macros shared by the sketch table modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, switched off while reset is held.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

>>> sv/fst_pkg.sv
// Shared types, constants and helpers of the fingerprint sketch table.
package fst_pkg;

  localparam int ROWS        = 4;
  localparam int COLUMNS     = 1024;
  localparam int COUNT_BITS  = 16;
  localparam int FINGER_BITS = 8;
  localparam int COL_BITS    = $clog2(COLUMNS);
  localparam int IN_IDX_W    = 10;
  localparam int IN_COUNT_W  = 16;
  localparam int COUNT_MAX   = (1 << COUNT_BITS) - 1;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 32;

  typedef logic [COL_BITS-1:0]    col_t;
  typedef logic [COUNT_BITS-1:0]  count_t;
  typedef logic [FINGER_BITS-1:0] fp_t;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_QUERY  = 2'd1,
    MODE_STRICT = 2'd2
  } mode_t;

  typedef struct packed {
    logic   covered;
    count_t count;
    fp_t    fp;
  } entry_t;

  typedef struct packed {
    logic [1:0]                   mode;
    logic [ROWS-1:0][IN_IDX_W-1:0] idx;
    fp_t                          fp;
    logic [IN_COUNT_W-1:0]        count;
  } item_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL
  } state_t;

  typedef struct packed {
    logic capture;   // latch the accepted word and start the bank reads
    logic commit;    // write back the update and load the output register
    logic clear_we;  // write zero at the clearing address
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_busy;
  } status_t;

  // Row r takes the index field of row r mod 4, reduced to the column range.
  function automatic col_t row_col(input logic [IN_IDX_W-1:0] idx);
    return col_t'(idx % COLUMNS);
  endfunction

  function automatic count_t sat_count(input logic [IN_COUNT_W-1:0] v);
    if (32'(v) > 32'(COUNT_MAX)) begin
      return count_t'(COUNT_MAX);
    end
    return count_t'(v);
  endfunction

endpackage

>>> sv/fst_bank.sv
// One row of sketch entries: single-port write, registered read.
module fst_bank (
  input  logic            clk,
  input  logic            we,
  input  fst_pkg::col_t   waddr,
  input  fst_pkg::entry_t wdata,
  input  logic            re,
  input  fst_pkg::col_t   raddr,
  output fst_pkg::entry_t rdata
);

  fst_pkg::entry_t mem [fst_pkg::COLUMNS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/fst_datapath.sv
// Row banks, insert update, query scan and the output register.
`include "assert_macros.svh"

module fst_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  fst_pkg::cmd_t                      cmd,
  output fst_pkg::status_t                   status,
  input  fst_pkg::item_t                     in_item,
  input  logic                               m_ready,
  output logic                               m_valid,
  output logic [fst_pkg::OUT_TDATA_W-1:0]    m_data
);

  fst_pkg::item_t                  item;
  fst_pkg::count_t                 item_n;
  fst_pkg::col_t                   clr_addr;
  fst_pkg::entry_t [fst_pkg::ROWS-1:0] rd_data;
  fst_pkg::entry_t [fst_pkg::ROWS-1:0] upd;
  logic                            placed;
  fst_pkg::entry_t                 res;
  logic                            res_placed;
  logic                            we;

  // Accepted word, held through the evaluate state.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item   <= in_item;
      item_n <= fst_pkg::sat_count(in_item.count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_we) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign we = cmd.clear_we ||
              (cmd.commit && fst_pkg::mode_t'(item.mode) == fst_pkg::MODE_INSERT);

  for (genvar r = 0; r < fst_pkg::ROWS; r++) begin : g_row
    fst_bank u_bank (
      .clk   (clk),
      .we    (we),
      .waddr (cmd.clear_we ? clr_addr : fst_pkg::row_col(item.idx[r % 4])),
      .wdata (cmd.clear_we ? fst_pkg::entry_t'('0) : upd[r]),
      .re    (cmd.capture),
      .raddr (fst_pkg::row_col(in_item.idx[r % 4])),
      .rdata (rd_data[r])
    );
  end

  // Insert: each row is updated on its own.
  always_comb begin
    placed = 1'b0;
    for (int r = 0; r < fst_pkg::ROWS; r++) begin
      if (rd_data[r].count == '0) begin
        upd[r] = '{covered: 1'b0, count: item_n, fp: item.fp};
        placed = 1'b1;
      end else if (rd_data[r].count < item_n) begin
        upd[r] = '{covered: 1'b1, count: item_n, fp: item.fp};
      end else begin
        upd[r] = '{covered: 1'b1, count: rd_data[r].count, fp: rd_data[r].fp};
      end
    end
  end

  // Query: minimum scan that stops at the first uncovered entry not below it; strict mode then answers zero.
  always_comb begin
    logic [fst_pkg::COUNT_BITS:0] minv;
    logic                         done;
    logic                         uncov;
    minv       = (fst_pkg::COUNT_BITS + 1)'(fst_pkg::COUNT_MAX + 1);
    done       = 1'b0;
    uncov      = 1'b0;
    res        = '0;
    res_placed = 1'b0;
    unique case (fst_pkg::mode_t'(item.mode)) inside
      fst_pkg::MODE_INSERT: begin
        res_placed = placed;
      end
      fst_pkg::MODE_QUERY, fst_pkg::MODE_STRICT: begin
        for (int r = 0; r < fst_pkg::ROWS; r++) begin
          uncov = !rd_data[r].covered &&
                  (rd_data[r].count != '0 || rd_data[r].fp != '0);
          if (!done) begin
            if ({1'b0, rd_data[r].count} < minv) begin
              minv = {1'b0, rd_data[r].count};
              res  = rd_data[r];
            end else if (uncov) begin
              res  = (fst_pkg::mode_t'(item.mode) == fst_pkg::MODE_STRICT) ?
                     fst_pkg::entry_t'('0) : rd_data[r];
              done = 1'b1;
            end
          end
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (cmd.commit) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_data <= fst_pkg::OUT_TDATA_W'({res_placed, res.fp, res.count, res.covered});
    end
  end

  assign status.clear_last = (clr_addr == fst_pkg::col_t'(fst_pkg::COLUMNS - 1));
  assign status.out_busy   = m_valid;

  `ASSERT_NEXT(a_commit_shows, clk, rst, cmd.commit, m_valid)
  `ASSERT_SAME(a_clear_alone, clk, rst, cmd.clear_we, !cmd.commit && !cmd.capture)

endmodule

>>> sv/fst_ctrl.sv
// Controller: clearing pass, accept, evaluate and hand-off sequencing.
`include "assert_macros.svh"

module fst_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_valid,
  output logic             s_ready,
  input  logic             m_ready,
  input  fst_pkg::status_t status,
  output fst_pkg::cmd_t    cmd
);

  fst_pkg::state_t state, state_next;
  logic            out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fst_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign out_free = !status.out_busy || m_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_ready    = 1'b0;
    unique case (state)
      fst_pkg::ST_CLEAR: begin
        cmd.clear_we = 1'b1;
        if (status.clear_last) begin
          state_next = fst_pkg::ST_IDLE;
        end
      end
      fst_pkg::ST_IDLE: begin
        s_ready     = 1'b1;
        cmd.capture = s_valid;
        if (s_valid) begin
          state_next = fst_pkg::ST_EVAL;
        end
      end
      fst_pkg::ST_EVAL: begin
        cmd.commit = out_free;
        if (out_free) begin
          state_next = fst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fst_pkg::ST_CLEAR;
      end
    endcase
  end

  `ASSERT_SAME(a_no_accept_clear, clk, rst, state == fst_pkg::ST_CLEAR, !s_ready)
  `ASSERT_SAME(a_commit_free, clk, rst, cmd.commit, state == fst_pkg::ST_EVAL && out_free)
  `ASSERT_NEXT(a_accept_eval, clk, rst, cmd.capture, state == fst_pkg::ST_EVAL)

endmodule

>>> sv/fingerprint_sketch_table.sv
// Top level of the fingerprint sketch table: ports, field packing, wiring.
//
//  Channel    Direction  Words carried
//  s_axis     in         one key: mode, four row indices, fingerprint, count
//  m_axis     out        one answer per key: entry fields and empty flag
//
// For each word the accepting edge reads all four row banks in parallel; in the
// evaluate state after it the block writes back and loads the output register.
// After reset a clearing pass over all 1024 columns zeroes every bank; s_tready is low.
// While an answer is stalled the next word is still taken and its banks read,
// but it is evaluated only once that answer can move, so no answer is lost.
module fingerprint_sketch_table (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // mode[1:0], row0_index[11:2], row1_index[21:12], row2_index[31:22],
  // row3_index[41:32], key_fingerprint[49:42], new_count[65:50], zero fill
  input  logic [fst_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // found_covered[0], found_count[16:1], found_fingerprint[24:17],
  // placed_in_empty[25], zero fill
  output logic [fst_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  fst_pkg::cmd_t    cmd;
  fst_pkg::status_t status;
  fst_pkg::item_t   in_item;

  // Unpack the incoming word into its fields.
  assign in_item.mode   = s_tdata[1:0];
  assign in_item.idx[0] = s_tdata[11:2];
  assign in_item.idx[1] = s_tdata[21:12];
  assign in_item.idx[2] = s_tdata[31:22];
  assign in_item.idx[3] = s_tdata[41:32];
  assign in_item.fp     = s_tdata[49:42];
  assign in_item.count  = s_tdata[65:50];

  fst_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_tvalid),
    .s_ready (s_tready),
    .m_ready (m_tready),
    .status  (status),
    .cmd     (cmd)
  );

  fst_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .status  (status),
    .in_item (in_item),
    .m_ready (m_tready),
    .m_valid (m_tvalid),
    .m_data  (m_tdata)
  );

endmodule
